/* rtl/core/assert_macros.svh */
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sra_checker: property failed");

// Next-cycle implication, disabled while reset is low.
`define SRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sra_checker: property failed");

`endif

/* rtl/core/sra_pkg.sv */
// Constants, microcode types and the control store of the skyline allocator.
package sra_pkg;

    localparam int ATLAS_WIDTH   = 1024;
    localparam int ATLAS_HEIGHT  = 512;
    localparam int BORDER_GROWTH = 2;

    localparam int AW     = $clog2(ATLAS_WIDTH);
    localparam int CNT_W  = $clog2(ATLAS_WIDTH + 1);
    localparam int HT_W   = $clog2(ATLAS_HEIGHT + 1);
    localparam int RW_W   = 11;
    localparam int RH_W   = 10;
    localparam int PW_W   = RW_W + 1;
    localparam int PH_W   = RH_W + 1;
    localparam int SUM_W  = 14;
    localparam int POSX_W = 10;
    localparam int POSY_W = 9;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ENABLE = 1'b0;

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] STEP_CLEAR   = 4'd0;
    localparam logic [PC_W-1:0] STEP_IDLE    = 4'd1;
    localparam logic [PC_W-1:0] STEP_CHK_EN  = 4'd2;
    localparam logic [PC_W-1:0] STEP_WIN     = 4'd3;
    localparam logic [PC_W-1:0] STEP_READ    = 4'd4;
    localparam logic [PC_W-1:0] STEP_CMP     = 4'd5;
    localparam logic [PC_W-1:0] STEP_ADVANCE = 4'd6;
    localparam logic [PC_W-1:0] STEP_DECIDE  = 4'd7;
    localparam logic [PC_W-1:0] STEP_WRITE   = 4'd8;
    localparam logic [PC_W-1:0] STEP_GRANT   = 4'd9;
    localparam logic [PC_W-1:0] STEP_FAIL    = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP      = 4'd0,
        OP_CLEAR    = 4'd1,
        OP_LOAD     = 4'd2,
        OP_WIN_INIT = 4'd3,
        OP_CMP      = 4'd4,
        OP_ADVANCE  = 4'd5,
        OP_WR_INIT  = 4'd6,
        OP_WRITE    = 4'd7,
        OP_GRANT    = 4'd8,
        OP_FAIL     = 4'd9
    } op_t;

    typedef enum logic [3:0] {
        COND_NEVER    = 4'd0,
        COND_ALWAYS   = 4'd1,
        COND_CLR_MORE = 4'd2,
        COND_NO_START = 4'd3,
        COND_DISABLED = 4'd4,
        COND_SCAN_END = 4'd5,
        COND_MORE     = 4'd6,
        COND_TOO_TALL = 4'd7,
        COND_WR_MORE  = 4'd8
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    // Jump to target when the condition holds, else fall through to the next step.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        begin
            unique case (pc)
                STEP_CLEAR:   w = '{OP_CLEAR,    COND_CLR_MORE, STEP_CLEAR};
                STEP_IDLE:    w = '{OP_LOAD,     COND_NO_START, STEP_IDLE};
                STEP_CHK_EN:  w = '{OP_NOP,      COND_DISABLED, STEP_FAIL};
                STEP_WIN:     w = '{OP_WIN_INIT, COND_SCAN_END, STEP_DECIDE};
                STEP_READ:    w = '{OP_NOP,      COND_NEVER,    STEP_IDLE};
                STEP_CMP:     w = '{OP_CMP,      COND_MORE,     STEP_READ};
                STEP_ADVANCE: w = '{OP_ADVANCE,  COND_ALWAYS,   STEP_WIN};
                STEP_DECIDE:  w = '{OP_WR_INIT,  COND_TOO_TALL, STEP_FAIL};
                STEP_WRITE:   w = '{OP_WRITE,    COND_WR_MORE,  STEP_WRITE};
                STEP_GRANT:   w = '{OP_GRANT,    COND_ALWAYS,   STEP_IDLE};
                STEP_FAIL:    w = '{OP_FAIL,     COND_ALWAYS,   STEP_IDLE};
                default:      w = '{OP_NOP,      COND_ALWAYS,   STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

/* rtl/core/skyline_rect_allocator.sv */
// Skyline rectangle allocator: microcoded sequencer over a column-height RAM.
// Per item: an enable check, then a read and a compare for each column of each candidate
// window, then on a grant one write per padded-width column; a disabled block goes to fail.
// Blocked windows skip ahead past the blocking column; one item at a time, next start
// is taken in the done cycle. Reset: a clearing pass writes zero to all ATLAS_WIDTH
// columns, one per cycle, with busy high; the result strobe is one cycle, never stalled.
module skyline_rect_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sra_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sra_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sra_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic [sra_pkg::RW_W-1:0]           rect_width,
    input  logic [sra_pkg::RH_W-1:0]           rect_height,
    output logic                               done,
    output logic                               granted,
    output logic [sra_pkg::POSX_W-1:0]         pos_x,
    output logic [sra_pkg::POSY_W-1:0]         pos_y
);

    sra_pkg::ucode_t uc;

    logic [sra_pkg::PC_W-1:0]   pc_reg, pc_next;
    logic                       enable_reg;
    logic [sra_pkg::PW_W-1:0]   pw_reg, pw_next;
    logic [sra_pkg::PH_W-1:0]   ph_reg, ph_next;
    logic [sra_pkg::CNT_W-1:0]  limit_reg, limit_next;
    logic [sra_pkg::CNT_W-1:0]  s_reg, s_next;
    logic [sra_pkg::CNT_W-1:0]  col_reg, col_next;
    logic [sra_pkg::CNT_W-1:0]  end_reg, end_next;
    logic [sra_pkg::HT_W-1:0]   top_reg, top_next;
    logic [sra_pkg::CNT_W-1:0]  maxpos_reg, maxpos_next;
    logic [sra_pkg::HT_W-1:0]   best_reg, best_next;
    logic [sra_pkg::CNT_W-1:0]  bestx_reg, bestx_next;
    logic                       blk_reg, blk_next;
    logic                       done_reg, done_next;
    logic                       granted_reg, granted_next;
    logic [sra_pkg::POSX_W-1:0] posx_reg, posx_next;
    logic [sra_pkg::POSY_W-1:0] posy_reg, posy_next;

    logic [sra_pkg::HT_W-1:0]   rdata;
    logic                       ram_we;
    logic [sra_pkg::HT_W-1:0]   ram_wdata;

    logic [sra_pkg::CNT_W-1:0]  col_inc;
    logic [sra_pkg::PW_W-1:0]   pw_in;
    logic [sra_pkg::SUM_W-1:0]  lim_full;
    logic [sra_pkg::SUM_W-1:0]  win_end_full;
    logic [sra_pkg::SUM_W-1:0]  wr_end_full;
    logic [sra_pkg::SUM_W-1:0]  newh_sum;
    logic [sra_pkg::SUM_W-1:0]  posx_full;
    logic [sra_pkg::SUM_W-1:0]  posy_full;
    logic                       blocked;
    logic                       too_tall;
    logic                       cond_true;
    logic                       cfg_wr;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == sra_pkg::REG_ENABLE)
        begin
            prdata[0] = enable_reg;
        end
    end

    sra_ram #(
        .WIDTH (sra_pkg::HT_W),
        .DEPTH (sra_pkg::ATLAS_WIDTH)
    ) u_column_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg[sra_pkg::AW-1:0]),
        .wdata (ram_wdata),
        .raddr (col_reg[sra_pkg::AW-1:0]),
        .rdata (rdata)
    );

    assign uc           = sra_pkg::ucode_rom(pc_reg);
    assign col_inc      = col_reg + 1'b1;
    assign pw_in        = {1'b0, rect_width} + sra_pkg::PW_W'(sra_pkg::BORDER_GROWTH);
    assign lim_full     = sra_pkg::SUM_W'(sra_pkg::ATLAS_WIDTH) - sra_pkg::SUM_W'(pw_in);
    assign win_end_full = sra_pkg::SUM_W'(s_reg) + sra_pkg::SUM_W'(pw_reg);
    assign wr_end_full  = sra_pkg::SUM_W'(bestx_reg) + sra_pkg::SUM_W'(pw_reg);
    assign newh_sum     = sra_pkg::SUM_W'(best_reg) + sra_pkg::SUM_W'(ph_reg);
    assign posx_full    = sra_pkg::SUM_W'(bestx_reg) + sra_pkg::SUM_W'(1);
    assign posy_full    = sra_pkg::SUM_W'(best_reg) + sra_pkg::SUM_W'(1);
    assign blocked      = rdata >= best_reg;
    assign too_tall     = newh_sum > sra_pkg::SUM_W'(sra_pkg::ATLAS_HEIGHT);
    assign busy         = pc_reg != sra_pkg::STEP_IDLE;

    // Branch condition select
    always_comb
    begin
        case (uc.cond)
            sra_pkg::COND_NEVER:    cond_true = 1'b0;
            sra_pkg::COND_ALWAYS:   cond_true = 1'b1;
            sra_pkg::COND_CLR_MORE:
                cond_true = col_reg != sra_pkg::CNT_W'(sra_pkg::ATLAS_WIDTH - 1);
            sra_pkg::COND_NO_START: cond_true = !start;
            sra_pkg::COND_DISABLED: cond_true = !enable_reg;
            sra_pkg::COND_SCAN_END: cond_true = s_reg >= limit_reg;
            sra_pkg::COND_MORE:     cond_true = !blocked && (col_inc != end_reg);
            sra_pkg::COND_TOO_TALL: cond_true = too_tall;
            sra_pkg::COND_WR_MORE:  cond_true = col_inc != end_reg;
            default:                cond_true = 1'b1;
        endcase
    end

    assign pc_next = cond_true ? uc.target : pc_reg + 1'b1;

    // Datapath driven by the control word
    always_comb
    begin
        pw_next      = pw_reg;
        ph_next      = ph_reg;
        limit_next   = limit_reg;
        s_next       = s_reg;
        col_next     = col_reg;
        end_next     = end_reg;
        top_next     = top_reg;
        maxpos_next  = maxpos_reg;
        best_next    = best_reg;
        bestx_next   = bestx_reg;
        blk_next     = blk_reg;
        done_next    = 1'b0;
        granted_next = granted_reg;
        posx_next    = posx_reg;
        posy_next    = posy_reg;
        ram_we       = 1'b0;
        ram_wdata    = '0;

        case (uc.op)
            sra_pkg::OP_CLEAR:
            begin
                ram_we   = 1'b1;
                col_next = col_inc;
            end
            sra_pkg::OP_LOAD:
            begin
                if (start)
                begin
                    pw_next    = pw_in;
                    ph_next    = {1'b0, rect_height} +
                                 sra_pkg::PH_W'(sra_pkg::BORDER_GROWTH);
                    best_next  = sra_pkg::HT_W'(sra_pkg::ATLAS_HEIGHT);
                    bestx_next = '0;
                    s_next     = '0;
                    if (sra_pkg::SUM_W'(pw_in) < sra_pkg::SUM_W'(sra_pkg::ATLAS_WIDTH))
                    begin
                        limit_next = lim_full[sra_pkg::CNT_W-1:0];
                    end
                    else
                    begin
                        limit_next = '0;
                    end
                end
            end
            sra_pkg::OP_WIN_INIT:
            begin
                col_next    = s_reg;
                end_next    = win_end_full[sra_pkg::CNT_W-1:0];
                top_next    = '0;
                maxpos_next = s_reg;
                blk_next    = 1'b0;
            end
            sra_pkg::OP_CMP:
            begin
                if (blocked)
                begin
                    blk_next = 1'b1;
                end
                else
                begin
                    // Keep the last position of the running maximum
                    if (rdata >= top_reg)
                    begin
                        top_next    = rdata;
                        maxpos_next = col_reg;
                    end
                    col_next = col_inc;
                end
            end
            sra_pkg::OP_ADVANCE:
            begin
                // Every start up to the blocking column fails: skip past it
                if (blk_reg)
                begin
                    s_next = col_inc;
                end
                else
                begin
                    best_next  = top_reg;
                    bestx_next = s_reg;
                    s_next     = maxpos_reg + 1'b1;
                end
            end
            sra_pkg::OP_WR_INIT:
            begin
                col_next = bestx_reg;
                end_next = wr_end_full[sra_pkg::CNT_W-1:0];
            end
            sra_pkg::OP_WRITE:
            begin
                ram_we    = 1'b1;
                ram_wdata = newh_sum[sra_pkg::HT_W-1:0];
                col_next  = col_inc;
            end
            sra_pkg::OP_GRANT:
            begin
                done_next    = 1'b1;
                granted_next = 1'b1;
                posx_next    = posx_full[sra_pkg::POSX_W-1:0];
                posy_next    = posy_full[sra_pkg::POSY_W-1:0];
            end
            sra_pkg::OP_FAIL:
            begin
                done_next    = 1'b1;
                granted_next = 1'b0;
                posx_next    = '0;
                posy_next    = '0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= sra_pkg::STEP_CLEAR;
            col_reg    <= '0;
            done_reg   <= 1'b0;
            enable_reg <= 1'b1;
        end
        else
        begin
            pc_reg   <= pc_next;
            col_reg  <= col_next;
            done_reg <= done_next;
            if (cfg_wr && (paddr[2] == sra_pkg::REG_ENABLE))
            begin
                enable_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pw_reg      <= pw_next;
        ph_reg      <= ph_next;
        limit_reg   <= limit_next;
        s_reg       <= s_next;
        end_reg     <= end_next;
        top_reg     <= top_next;
        maxpos_reg  <= maxpos_next;
        best_reg    <= best_next;
        bestx_reg   <= bestx_next;
        blk_reg     <= blk_next;
        granted_reg <= granted_next;
        posx_reg    <= posx_next;
        posy_reg    <= posy_next;
    end

    assign done    = done_reg;
    assign granted = granted_reg;
    assign pos_x   = posx_reg;
    assign pos_y   = posy_reg;

endmodule

/* rtl/core/sra_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module sra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/sra_checker.sv */
// Port-level checks for the skyline allocator, bound to the top level.
`include "assert_macros.svh"

module sra_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic                       granted,
    input logic [sra_pkg::POSX_W-1:0] pos_x,
    input logic [sra_pkg::POSY_W-1:0] pos_y
);

    `SRA_ASSERT_NEXT(a_done_one_beat, clk, rst_n, done, !done)
    `SRA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `SRA_ASSERT_NOW(a_done_after_busy, clk, rst_n, done, !busy && $past(busy))
    `SRA_ASSERT_NOW(a_fail_zero, clk, rst_n, done && !granted, pos_x == '0 && pos_y == '0)
    `SRA_ASSERT_NOW(a_grant_inside, clk, rst_n, done && granted, pos_x != '0 && pos_y != '0)

endmodule

bind skyline_rect_allocator sra_checker u_sra_checker (.*);

/* tb/sv/skyline_rect_allocator_tb.sv */
// Self-checking testbench for the skyline rectangle allocator.
`timescale 1ns / 100ps

module skyline_rect_allocator_tb;

    localparam int REG_STRIDE = 4;
    localparam bit [sra_pkg::APB_ADDR_W-1:0] ENABLE_ADDR =
        sra_pkg::APB_ADDR_W'(REG_STRIDE * sra_pkg::REG_ENABLE);
    // register index 1 is not implemented; writes there must be dropped
    localparam bit [sra_pkg::APB_ADDR_W-1:0] SPARE_ADDR =
        sra_pkg::APB_ADDR_W'(ENABLE_ADDR + REG_STRIDE);
    localparam int RANDOM_RECTS = 120;

    typedef struct packed {
        bit                        granted;
        bit [sra_pkg::POSX_W-1:0]  x;
        bit [sra_pkg::POSY_W-1:0]  y;
    } placement_t;

    typedef enum bit {ROW_REQ, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t                     kind;
        bit [sra_pkg::RW_W-1:0]        rw;
        bit [sra_pkg::RH_W-1:0]        rh;
        bit [sra_pkg::APB_ADDR_W-1:0]  addr;
        bit [sra_pkg::APB_DATA_W-1:0]  data;
        bit                            typed;
        placement_t                    exp;
    } directed_row_t;

    localparam placement_t REFUSED    = '0;
    localparam placement_t FIRST_SLOT = '{1'b1, 10'd1, 9'd1};

    localparam directed_row_t DIRECTED_ROWS [24] = '{
        '{ROW_REQ, 11'd0,    10'd0,    '0,          32'h0,         1'b1, FIRST_SLOT},
        '{ROW_REQ, 11'd2047, 10'd1023, '0,          32'h0,         1'b1, REFUSED},
        '{ROW_REQ, 11'd1022, 10'd5,    '0,          32'h0,         1'b1, REFUSED},
        '{ROW_REQ, 11'd1021, 10'd0,    '0,          32'h0,         1'b0, REFUSED},
        '{ROW_REQ, 11'd5,    10'd1023, '0,          32'h0,         1'b1, REFUSED},
        '{ROW_REQ, 11'd0,    10'd510,  '0,          32'h0,         1'b0, REFUSED},
        '{ROW_REQ, 11'd1024, 10'd100,  '0,          32'h0,         1'b1, REFUSED},
        '{ROW_REQ, 11'd1,    10'd1,    '0,          32'h0,         1'b0, REFUSED},
        '{ROW_REG, 11'd0,    10'd0,    ENABLE_ADDR, 32'h0,         1'b0, REFUSED},
        '{ROW_REQ, 11'd0,    10'd0,    '0,          32'h0,         1'b1, REFUSED},
        '{ROW_REQ, 11'd10,   10'd10,   '0,          32'h0,         1'b1, REFUSED},
        '{ROW_REQ, 11'd2047, 10'd1023, '0,          32'h0,         1'b1, REFUSED},
        '{ROW_REG, 11'd0,    10'd0,    SPARE_ADDR,  32'h1,         1'b0, REFUSED},
        '{ROW_REQ, 11'd3,    10'd3,    '0,          32'h0,         1'b1, REFUSED},
        '{ROW_REG, 11'd0,    10'd0,    ENABLE_ADDR, 32'hFFFF_FFFE, 1'b0, REFUSED},
        '{ROW_REQ, 11'd7,    10'd7,    '0,          32'h0,         1'b1, REFUSED},
        '{ROW_REG, 11'd0,    10'd0,    ENABLE_ADDR, 32'hFFFF_FFFF, 1'b0, REFUSED},
        '{ROW_REQ, 11'd300,  10'd200,  '0,          32'h0,         1'b0, REFUSED},
        '{ROW_REQ, 11'd1020, 10'd0,    '0,          32'h0,         1'b0, REFUSED},
        '{ROW_REQ, 11'd512,  10'd256,  '0,          32'h0,         1'b0, REFUSED},
        '{ROW_REQ, 11'd100,  10'd510,  '0,          32'h0,         1'b0, REFUSED},
        '{ROW_REQ, 11'd0,    10'd0,    '0,          32'h0,         1'b0, REFUSED},
        '{ROW_REQ, 11'd2,    10'd508,  '0,          32'h0,         1'b0, REFUSED},
        '{ROW_REQ, 11'd1023, 10'd1023, '0,          32'h0,         1'b1, REFUSED}
    };

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [sra_pkg::APB_ADDR_W-1:0]    paddr = '0;
    logic [sra_pkg::APB_DATA_W-1:0]    pwdata = '0;
    logic [sra_pkg::APB_DATA_W-1:0]    prdata;
    logic                              pready;
    logic                              start = 1'b0;
    logic                              busy;
    logic [sra_pkg::RW_W-1:0]          rect_width = '0;
    logic [sra_pkg::RH_W-1:0]          rect_height = '0;
    logic                              done;
    logic                              granted;
    logic [sra_pkg::POSX_W-1:0]        pos_x;
    logic [sra_pkg::POSY_W-1:0]        pos_y;

    // mirror of the block's state
    bit [sra_pkg::HT_W-1:0]  skyline [sra_pkg::ATLAS_WIDTH];
    bit                      atlas_on = 1'b1;

    placement_t     pending_placements [$];
    int             mismatch_count = 0;
    int             cfg_mismatch_count = 0;
    int             sender_idle_pct = 35;

    skyline_rect_allocator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .done        (done),
        .granted     (granted),
        .pos_x       (pos_x),
        .pos_y       (pos_y)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Lowest-then-leftmost skyline fit of a bordered rectangle; raises the span on a grant.
    function automatic placement_t place_rect(input bit [sra_pkg::RW_W-1:0] w,
                                              input bit [sra_pkg::RH_W-1:0] h);
        placement_t              p = '0;
        int unsigned             pw;
        int unsigned             ph;
        int unsigned             best;
        int unsigned             best_x;
        int unsigned             span;
        int unsigned             top;
        bit                      fits;
        bit [sra_pkg::AW-1:0]    col;
        begin
            if (!atlas_on)
                return p;
            pw = w + sra_pkg::BORDER_GROWTH;
            ph = h + sra_pkg::BORDER_GROWTH;
            best = sra_pkg::ATLAS_HEIGHT;
            best_x = 0;
            span = (pw < sra_pkg::ATLAS_WIDTH) ? sra_pkg::ATLAS_WIDTH - pw : 0;
            for (int unsigned s = 0; s < span; s++)
            begin
                top = 0;
                fits = 1'b1;
                for (int unsigned k = 0; k < pw && fits; k++)
                begin
                    col = sra_pkg::AW'(s + k);
                    if (32'(skyline[col]) >= best)
                        fits = 1'b0;
                    else if (32'(skyline[col]) > top)
                        top = 32'(skyline[col]);
                end
                // keep only a strictly lower top
                if (fits)
                begin
                    best = top;
                    best_x = s;
                end
            end
            if (best + ph > sra_pkg::ATLAS_HEIGHT)
                return p;
            for (int unsigned k = 0; k < pw; k++)
            begin
                col = sra_pkg::AW'(best_x + k);
                skyline[col] = sra_pkg::HT_W'(best + ph);
            end
            p.granted = 1'b1;
            p.x = sra_pkg::POSX_W'(best_x + 1);
            p.y = sra_pkg::POSY_W'(best + 1);
            return p;
        end
    endfunction

    // Hold start low until every placement is back and the block is idle.
    task automatic drain();
        begin
            start <= 1'b0;
            while (pending_placements.size() != 0 || busy)
                @(posedge clk);
        end
    endtask

    task automatic set_register(input bit [sra_pkg::APB_ADDR_W-1:0] addr,
                                input bit [sra_pkg::APB_DATA_W-1:0] data);
        begin
            drain();
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= addr;
            pwdata <= data;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (addr == ENABLE_ADDR)
                atlas_on = data[0];
            // read the enable register back
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= ENABLE_ADDR;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (prdata !== sra_pkg::APB_DATA_W'(atlas_on))
            begin
                $error("prdata: expected %0d, got %0d", atlas_on, prdata);
                cfg_mismatch_count++;
            end
            psel <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic issue_rect(input bit [sra_pkg::RW_W-1:0] w,
                              input bit [sra_pkg::RH_W-1:0] h,
                              input bit typed, input placement_t typed_exp);
        placement_t due;
        begin
            rect_width <= w;
            rect_height <= h;
            // drop start in a share of the cycles set by sender_idle_pct
            forever
            begin
                start <= ($urandom_range(0, 99) >= sender_idle_pct);
                @(posedge clk);
                if (start && !busy)
                    break;
            end
            due = place_rect(w, h);
            pending_placements.push_back(typed ? typed_exp : due);
        end
    endtask

    always @(posedge clk)
    begin : check_placement
        placement_t want;
        if (rst_n && done)
        begin
            if (pending_placements.size() == 0)
            begin
                $error("result beat with no placement pending: granted %0d x %0d y %0d",
                       granted, pos_x, pos_y);
                mismatch_count++;
            end
            else
            begin
                want = pending_placements.pop_front();
                if (granted !== want.granted)
                begin
                    $error("granted: expected %0d, got %0d", want.granted, granted);
                    mismatch_count++;
                end
                if (pos_x !== want.x)
                begin
                    $error("pos_x: expected %0d, got %0d", want.x, pos_x);
                    mismatch_count++;
                end
                if (pos_y !== want.y)
                begin
                    $error("pos_y: expected %0d, got %0d", want.y, pos_y);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned             pick;
        bit [sra_pkg::RW_W-1:0]  w;
        bit [sra_pkg::RH_W-1:0]  h;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].kind == ROW_REG)
                set_register(DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].data);
            else
                issue_rect(DIRECTED_ROWS[i].rw, DIRECTED_ROWS[i].rh,
                           DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].exp);
        end

        for (int n = 0; n < RANDOM_RECTS; n++)
        begin
            if (n < RANDOM_RECTS / 3)
                sender_idle_pct = 35;
            else if (n < 2 * RANDOM_RECTS / 3)
                sender_idle_pct = 54;
            else
                sender_idle_pct = 0;
            // a short disabled stretch partway through
            if (n == 60)
                set_register(ENABLE_ADDR, $urandom & ~32'h1);
            if (n == 68)
                set_register(ENABLE_ADDR, $urandom | 32'h1);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                w = sra_pkg::RW_W'($urandom_range(0, 40));
                h = sra_pkg::RH_W'($urandom_range(0, 40));
            end
            else if (pick < 88)
            begin
                w = sra_pkg::RW_W'($urandom_range(0, 320));
                h = sra_pkg::RH_W'($urandom_range(0, 160));
            end
            else if (pick < 94)
            begin
                w = sra_pkg::RW_W'($urandom_range(900, 1023));
                h = sra_pkg::RH_W'($urandom_range(0, 60));
            end
            else
            begin
                w = sra_pkg::RW_W'($urandom_range(0, 2047));
                h = sra_pkg::RH_W'($urandom_range(0, 1023));
            end
            issue_rect(w, h, 1'b0, REFUSED);
            if (n % 25 == 24)
                drain();
        end

        drain();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && cfg_mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #400_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
